>>> hdl/hrs_pkg.sv
// hrs_pkg: shared types, constants and functions for the hex ring/spiral generator
// no dependencies; used by hrs_front, hrs_cmd_fifo, hrs_walk and the top level

package hrs_pkg;

  // largest ring distance walked; larger requests saturate to it
  localparam logic [2:0] MAX_RADIUS = 3'd4;

  // command queue between front and walker
  localparam int CMD_DEPTH = 2;

  // classified request handed from front to walker
  typedef struct packed {
    logic [15:0] cq;     // center q
    logic [15:0] cr;     // center r
    logic [2:0]  k0;     // first ring walked (0 = center first)
    logic [5:0]  cnt;    // cells to emit, never zero
  } cmd_t;

  // number of cells in the full listing
  function automatic logic [5:0] cell_count(input logic op, input logic [2:0] k);
    logic [5:0] kw;
    logic [5:0] res;
    kw = {3'b000, k};
    if (op) begin
      res = 6'd1 + 6'd3 * kw * (kw + 6'd1);
    end else if (k == 3'd0) begin
      res = 6'd1;
    end else begin
      res = kw * 6'd6;
    end
    return res;
  endfunction

  // axial step along side direction 0..5
  function automatic logic [15:0] dir_dq(input logic [2:0] side);
    logic [15:0] d;
    case (side)
      3'd0, 3'd1: d = 16'h0001;
      3'd3, 3'd4: d = 16'hFFFF;
      default:    d = 16'h0000;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] dir_dr(input logic [2:0] side);
    logic [15:0] d;
    case (side)
      3'd4, 3'd5: d = 16'h0001;
      3'd1, 3'd2: d = 16'hFFFF;
      default:    d = 16'h0000;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/hex_ring_spiral_generator_core.sv
// hex_ring_spiral_generator_core: top level of the hex ring / spiral cell generator
// depends on hrs_pkg, hrs_front, hrs_cmd_fifo, hrs_walk
//
//   channel   handshake           payload                              transaction
//   request   push / full         op center_q center_r radius limit    push & !full
//   cell      empty / pop         cell_q cell_r position last          pop & !empty
//
// one cell comes out per cycle while the walker is busy and the output is drained;
// a request is loaded into the walker and then emits its cells, at most 61 for a radius 4 spiral
// the walker loads the next command from the queue only while it is idle
// reset (rst, synchronous) empties the command queue and the output register
// the front keeps taking requests while the walker stalls, until the two-entry queue fills
// a request with limit 0 is taken and produces no cell

module hex_ring_spiral_generator_core (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [15:0] center_q,
  input  logic signed [15:0] center_r,
  input  logic [2:0]         radius,
  input  logic [5:0]         limit,
  // cell side
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] cell_q,
  output logic signed [15:0] cell_r,
  output logic [5:0]         position,
  output logic               last
);

  // front to queue
  logic          q_full;
  logic          q_push;
  hrs_pkg::cmd_t q_wdata;

  // queue to walker
  logic          cmd_valid;
  logic          cmd_pop;
  hrs_pkg::cmd_t cmd;

  // walker output register
  logic          out_valid;
  logic [15:0]   out_q;
  logic [15:0]   out_r;

  // classify requests: saturate radius, clip the cell count to limit
  hrs_front u_front (
    .push     (push),
    .full     (full),
    .op       (op),
    .center_q (center_q),
    .center_r (center_r),
    .radius   (radius),
    .limit    (limit),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // decouples request acceptance from the cell walk
  hrs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd)
  );

  // walk rings, one cell per cycle into the output register while the output is drained
  hrs_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_pop   (pop),
    .out_q     (out_q),
    .out_r     (out_r),
    .out_pos   (position),
    .out_last  (last)
  );

  assign empty  = !out_valid;
  assign cell_q = out_q;
  assign cell_r = out_r;

endmodule

>>> hdl/hrs_front.sv
// hrs_front: accepts requests, saturates the radius and works out how many cells to emit
// depends on hrs_pkg

module hrs_front (
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [15:0]       center_q,
  input  logic [15:0]       center_r,
  input  logic [2:0]        radius,
  input  logic [5:0]        limit,
  input  logic              q_full,
  output logic              q_push,
  output hrs_pkg::cmd_t     q_data
);

  logic [2:0] rad_sat;
  logic [5:0] cells;
  logic [5:0] cnt;

  always_comb begin
    rad_sat = (radius > hrs_pkg::MAX_RADIUS) ? hrs_pkg::MAX_RADIUS : radius;
    cells   = hrs_pkg::cell_count(op, rad_sat);
    cnt     = (limit < cells) ? limit : cells;
    q_data.cq  = center_q;
    q_data.cr  = center_r;
    q_data.k0  = op ? 3'd0 : rad_sat;
    q_data.cnt = cnt;
  end

  assign full   = q_full;
  // a request with nothing to emit is taken and dropped here
  assign q_push = push && !q_full && (cnt != 6'd0);

endmodule

>>> hdl/hrs_cmd_fifo.sv
// hrs_cmd_fifo: short command queue between the front and the walker
// depends on hrs_pkg

module hrs_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  hrs_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output hrs_pkg::cmd_t rd_data
);

  localparam int PtrW = $clog2(hrs_pkg::CMD_DEPTH);
  localparam int CntW = $clog2(hrs_pkg::CMD_DEPTH + 1);

  hrs_pkg::cmd_t      mem [hrs_pkg::CMD_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_wr;
  logic               do_rd;

  assign full     = (count == CntW'(hrs_pkg::CMD_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(hrs_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(hrs_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/hrs_walk.sv
// hrs_walk: walks rings cell by cell and holds the result in an output register
// depends on hrs_pkg

module hrs_walk (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  hrs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_pop,
  output logic [15:0]   out_q,
  output logic [15:0]   out_r,
  output logic [5:0]    out_pos,
  output logic          out_last
);

  logic        busy;
  logic [15:0] cq;
  logic [15:0] cr;
  logic [15:0] q;
  logic [15:0] r;
  logic [2:0]  k;
  logic [2:0]  side;
  logic [2:0]  step;
  logic [5:0]  pos;
  logic [5:0]  cnt;

  logic        emit;
  logic        is_last;
  logic        side_end;
  logic        ring_end;
  logic [2:0]  k_next;

  assign cmd_pop  = !busy && cmd_valid;
  assign emit     = busy && (!out_valid || out_pop);
  assign is_last  = (pos == cnt - 6'd1);
  assign side_end = (step == k - 3'd1);
  assign ring_end = (k == 3'd0) || (side_end && side == 3'd5);
  assign k_next   = k + 3'd1;

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_pop) begin
      busy <= 1'b1;
    end else if (emit && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cq   <= cmd.cq;
      cr   <= cmd.cr;
      cnt  <= cmd.cnt;
      k    <= cmd.k0;
      q    <= cmd.cq - {13'd0, cmd.k0};
      r    <= cmd.cr + {13'd0, cmd.k0};
      side <= 3'd0;
      step <= 3'd0;
      pos  <= 6'd0;
    end else if (emit) begin
      pos <= pos + 6'd1;
      if (ring_end) begin
        // next ring starts one step out along direction 4
        k    <= k_next;
        q    <= cq - {13'd0, k_next};
        r    <= cr + {13'd0, k_next};
        side <= 3'd0;
        step <= 3'd0;
      end else begin
        q <= q + hrs_pkg::dir_dq(side);
        r <= r + hrs_pkg::dir_dr(side);
        if (side_end) begin
          step <= 3'd0;
          side <= side + 3'd1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q    <= q;
      out_r    <= r;
      out_pos  <= pos;
      out_last <= is_last;
    end
  end

endmodule

>>> hdl/hrs_checker.sv
// hrs_checker: port-level assertions for the hex ring / spiral generator, bound to the top
// depends on hex_ring_spiral_generator_core (bind target)

module hrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] cell_q,
  input logic signed [15:0] cell_r,
  input logic [5:0]         position,
  input logic               last
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible after reset");

  // cells of one request come out in listing order
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (empty || position == $past(position) + 6'd1))
    else $error("position did not advance by one");

  // a new request starts at position zero
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last) |=> (empty || position == 6'd0))
    else $error("request did not start at position zero");

  // largest listing has 61 cells
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> position <= 6'd60)
    else $error("position out of range");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cell_q) && $stable(cell_r) && $stable(position)))
    else $error("stalled result changed");

endmodule

bind hex_ring_spiral_generator_core hrs_checker u_hrs_checker (.*);
